FILE: hdl/mbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask bounding box package
// Shared types and constants for the mask bounding box unit.
// ----------------------------------------------------------------------------
package mbb_pkg;

  localparam int COL_W      = 7;
  localparam int PIX_PER_B  = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 11;
  localparam int RBYTES_W   = 8;
  localparam int CFG_DATA_W = 11;
  localparam int BOX_XY_W   = 10;
  localparam int BOX_WH_W   = 11;

  localparam logic [RBYTES_W-1:0] ROW_BYTES_MAX = 8'd128;

  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd400;
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 11'd240;
  localparam logic [RBYTES_W-1:0] RST_ROW_BYTES    = 8'd50;
  localparam logic                RST_MASK_ENABLE  = 1'b1;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ROW_BYTES    = 2'd2,
    REG_MASK_ENABLE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic [RBYTES_W-1:0] row_bytes_eff;
    logic                mask_enable;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] left;
    logic [2:0] right;
  } scan_t;

  typedef struct packed {
    logic [BOX_XY_W-1:0] box_x;
    logic [BOX_XY_W-1:0] box_y;
    logic [BOX_WH_W-1:0] box_w;
    logic [BOX_WH_W-1:0] box_h;
  } box_t;

endpackage

FILE: hdl/mbb_byte_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask byte scanner
// Masks off pixels beyond the image width and finds the leftmost and
// rightmost set pixel of one mask byte.
// ----------------------------------------------------------------------------
module mbb_byte_scan
  import mbb_pkg::*;
(
  input  logic [7:0]         mask_byte,
  input  logic [COL_W-1:0]   byte_column,
  input  logic [WIDTH_W-1:0] width_eff,
  output scan_t              scan
);

  int         remain;
  int         valid_cnt;
  logic [7:0] bits;

  always_comb begin
    remain = int'(width_eff) - int'(byte_column) * PIX_PER_B;
    if (remain <= 0) begin
      valid_cnt = 0;
    end else if (remain >= PIX_PER_B) begin
      valid_cnt = PIX_PER_B;
    end else begin
      valid_cnt = remain;
    end
    for (int j = 0; j < 8; j++) begin
      bits[j] = mask_byte[j] & ((7 - j) < valid_cnt);
    end
  end

  always_comb begin
    scan.hit   = |bits;
    scan.left  = 3'd0;
    scan.right = 3'd7;
    for (int j = 0; j < 8; j++) begin
      if (bits[j]) begin
        scan.left = 3'(7 - j);
      end
    end
    for (int j = 7; j >= 0; j--) begin
      if (bits[j]) begin
        scan.right = 3'(7 - j);
      end
    end
  end

endmodule

FILE: hdl/mbb_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box tracker
// Keeps the raster position and the running extents of set pixels, and
// forms the frame result on the last byte of a frame.
// ----------------------------------------------------------------------------
module mbb_tracker
  import mbb_pkg::*;
#(
  parameter int XW = 11,
  parameter int YW = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] mask_byte,
  input  cfg_t       cfg,
  output logic       frame_end,
  output box_t       box
);

  logic [COL_W-1:0] byte_column_r, byte_column_nxt;
  logic [YW-1:0]    row_index_r, row_index_nxt;
  logic             any_found_r, any_found_nxt;
  logic [XW-1:0]    least_x_r, least_x_nxt;
  logic [XW-1:0]    end_x_r, end_x_nxt;
  logic [YW-1:0]    least_y_r, least_y_nxt;
  logic [YW-1:0]    end_y_r, end_y_nxt;

  scan_t         scan;
  logic [XW-1:0] xl, xr;
  logic [YW-1:0] row_end;
  logic          col_last, row_last;
  logic          upd_found;
  logic [XW-1:0] upd_least_x, upd_end_x;
  logic [YW-1:0] upd_least_y, upd_end_y;

  logic [XW+BOX_XY_W-1:0] x_ext;
  logic [YW+BOX_XY_W-1:0] y_ext;
  logic [XW+BOX_WH_W-1:0] w_ext;
  logic [YW+BOX_WH_W-1:0] h_ext;

  mbb_byte_scan u_scan (
    .mask_byte   (mask_byte),
    .byte_column (byte_column_r),
    .width_eff   (cfg.width_eff),
    .scan        (scan)
  );

  always_comb begin
    xl       = XW'(int'(byte_column_r) * PIX_PER_B + int'(scan.left));
    xr       = XW'(int'(byte_column_r) * PIX_PER_B + int'(scan.right) + 1);
    row_end  = row_index_r + 1'b1;
    col_last = (int'(byte_column_r) + 1) >= int'(cfg.row_bytes_eff);
    row_last = (int'(row_index_r) + 1) >= int'(cfg.height_eff);
    frame_end = col_last && row_last;
  end

  always_comb begin
    upd_found   = any_found_r;
    upd_least_x = least_x_r;
    upd_end_x   = end_x_r;
    upd_least_y = least_y_r;
    upd_end_y   = end_y_r;
    if (scan.hit) begin
      if (!any_found_r) begin
        upd_found   = 1'b1;
        upd_least_x = xl;
        upd_end_x   = xr;
        upd_least_y = row_index_r;
        upd_end_y   = row_end;
      end else begin
        if (xl < least_x_r)          upd_least_x = xl;
        if (xr > end_x_r)            upd_end_x   = xr;
        if (row_index_r < least_y_r) upd_least_y = row_index_r;
        if (row_end > end_y_r)       upd_end_y   = row_end;
      end
    end
  end

  always_comb begin
    x_ext = {{BOX_XY_W{1'b0}}, upd_least_x};
    y_ext = {{BOX_XY_W{1'b0}}, upd_least_y};
    w_ext = {{BOX_WH_W{1'b0}}, upd_end_x - upd_least_x};
    h_ext = {{BOX_WH_W{1'b0}}, upd_end_y - upd_least_y};
    if (!cfg.mask_enable) begin
      box.box_x = '0;
      box.box_y = '0;
      box.box_w = cfg.width_eff;
      box.box_h = cfg.height_eff;
    end else if (upd_found) begin
      box.box_x = x_ext[BOX_XY_W-1:0];
      box.box_y = y_ext[BOX_XY_W-1:0];
      box.box_w = w_ext[BOX_WH_W-1:0];
      box.box_h = h_ext[BOX_WH_W-1:0];
    end else begin
      box = '0;
    end
  end

  always_comb begin
    byte_column_nxt = byte_column_r;
    row_index_nxt   = row_index_r;
    any_found_nxt   = any_found_r;
    least_x_nxt     = least_x_r;
    end_x_nxt       = end_x_r;
    least_y_nxt     = least_y_r;
    end_y_nxt       = end_y_r;
    if (step) begin
      any_found_nxt = upd_found;
      least_x_nxt   = upd_least_x;
      end_x_nxt     = upd_end_x;
      least_y_nxt   = upd_least_y;
      end_y_nxt     = upd_end_y;
      if (!col_last) begin
        byte_column_nxt = byte_column_r + 1'b1;
      end else begin
        byte_column_nxt = '0;
        if (!row_last) begin
          row_index_nxt = row_end;
        end else begin
          row_index_nxt = '0;
          any_found_nxt = 1'b0;
          least_x_nxt   = '0;
          end_x_nxt     = '0;
          least_y_nxt   = '0;
          end_y_nxt     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_column_r <= '0;
      row_index_r   <= '0;
      any_found_r   <= 1'b0;
      least_x_r     <= '0;
      end_x_r       <= '0;
      least_y_r     <= '0;
      end_y_r       <= '0;
    end else begin
      byte_column_r <= byte_column_nxt;
      row_index_r   <= row_index_nxt;
      any_found_r   <= any_found_nxt;
      least_x_r     <= least_x_nxt;
      end_x_r       <= end_x_nxt;
      least_y_r     <= least_y_nxt;
      end_y_r       <= end_y_nxt;
    end
  end

endmodule

FILE: hdl/mask_bounding_box_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask bounding box unit
// Streams a 1-bit mask byte by byte and reports the bounding box of its set
// pixels once per frame.
// ----------------------------------------------------------------------------
// The unit takes one mask byte per clock cycle in raster order, most
// significant bit leftmost. Each byte passes an input register and then
// updates the extents; the last byte of a frame loads the result register,
// and the next frame may start at once. The input stalls only when a frame
// result is ready to load while the previous one still waits.
// Configuration is to be written over the cfg_ channel while the unit is
// idle; the unit itself does not enforce this.
module mask_bounding_box_unit
  import mbb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_mask_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BOX_XY_W-1:0]   out_box_x,
  output logic [BOX_XY_W-1:0]   out_box_y,
  output logic [BOX_WH_W-1:0]   out_box_w,
  output logic [BOX_WH_W-1:0]   out_box_h,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);

  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;
  logic [RBYTES_W-1:0] row_bytes_r;
  logic                mask_enable_r;
  cfg_t                cfg;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_go, s1_load, step;

  logic frame_end;
  box_t box;
  logic out_valid_r, out_valid_nxt;
  box_t out_box_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      row_bytes_r    <= RST_ROW_BYTES;
      mask_enable_r  <= RST_MASK_ENABLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[HEIGHT_W-1:0];
        REG_ROW_BYTES:    row_bytes_r    <= cfg_data[RBYTES_W-1:0];
        REG_MASK_ENABLE:  mask_enable_r  <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    if (int'(image_width_r) > MAX_WIDTH) begin
      cfg.width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      cfg.width_eff = image_width_r;
    end
    priority if (image_height_r == '0) begin
      cfg.height_eff = HEIGHT_W'(1);
    end else if (int'(image_height_r) > MAX_HEIGHT) begin
      cfg.height_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      cfg.height_eff = image_height_r;
    end
    priority if (row_bytes_r == '0) begin
      cfg.row_bytes_eff = RBYTES_W'(1);
    end else if (row_bytes_r > ROW_BYTES_MAX) begin
      cfg.row_bytes_eff = ROW_BYTES_MAX;
    end else begin
      cfg.row_bytes_eff = row_bytes_r;
    end
    cfg.mask_enable = mask_enable_r;
  end

  mbb_tracker #(
    .XW (XW),
    .YW (YW)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .mask_byte (s1_byte_r),
    .cfg       (cfg),
    .frame_end (frame_end),
    .box       (box)
  );

  always_comb begin
    s1_go        = !frame_end || !out_valid_r || !out_stall;
    step         = s1_valid_r && s1_go;
    in_stall     = s1_valid_r && !s1_go;
    s1_load      = in_valid && !in_stall;
    s1_valid_nxt = s1_load || (s1_valid_r && !s1_go);
    out_valid_nxt = (step && frame_end) || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_byte_r <= in_mask_byte;
    end
    if (step && frame_end) begin
      out_box_r <= box;
    end
  end

  assign out_valid = out_valid_r;
  assign out_box_x = out_box_r.box_x;
  assign out_box_y = out_box_r.box_y;
  assign out_box_w = out_box_r.box_w;
  assign out_box_h = out_box_r.box_h;

endmodule
